>>> hw/rtl/fupa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_pkg
// Shared types, constants and the operation class table of the unit pool
// allocator.
// ----------------------------------------------------------------------------
package fupa_pkg;

  localparam int MAX_UNITS   = 8;
  localparam int NUM_POOLS   = 5;
  localparam int TIME_W      = 32;
  localparam int CLASS_W     = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int POOL_W      = 3;
  localparam int LAT_W       = 5;
  localparam int UNIT_IDX_W  = 3;
  localparam int FREE_W      = 4;
  localparam int UNITS_RESET = 4;

  // pool numbers, also the register indexes of the unit counts
  localparam logic [POOL_W-1:0] POOL_IALU = 3'd0;
  localparam logic [POOL_W-1:0] POOL_IMUL = 3'd1;
  localparam logic [POOL_W-1:0] POOL_FALU = 3'd2;
  localparam logic [POOL_W-1:0] POOL_FMUL = 3'd3;
  localparam logic [POOL_W-1:0] POOL_MEM  = 3'd4;

  // request modes
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_CLAIM = 1'b1;

  // operation classes
  localparam logic [CLASS_W-1:0] CLS_NONE  = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_IALU  = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_IMUL0 = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_IMUL1 = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_FALU0 = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_FALU1 = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_FALU2 = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_FMUL0 = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_FMUL1 = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_FMUL2 = 4'd9;
  localparam logic [CLASS_W-1:0] CLS_MEM0  = 4'd10;
  localparam logic [CLASS_W-1:0] CLS_MEM1  = 4'd11;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic              has_pool;
    logic [POOL_W-1:0] pool;
    logic [LAT_W-1:0]  exec_lat;
    logic [LAT_W-1:0]  issue_lat;
  } class_info_t;

  // broadcast from the control to every cell of the row
  typedef struct packed {
    logic              claim;
    logic              cfg_we;
    logic [POOL_W-1:0] cfg_pool;
    logic [POOL_W-1:0] pool;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] rt_new;
  } cell_ctrl_t;

  function automatic class_info_t class_info(input logic [CLASS_W-1:0] cls);
    class_info_t ci;
    ci = '{has_pool: 1'b0, pool: POOL_IALU, exec_lat: 5'd0, issue_lat: 5'd0};
    case (cls)
      CLS_IALU:  ci = '{1'b1, POOL_IALU, 5'd1,  5'd1};
      CLS_IMUL0: ci = '{1'b1, POOL_IMUL, 5'd2,  5'd1};
      CLS_IMUL1: ci = '{1'b1, POOL_IMUL, 5'd1,  5'd1};
      CLS_FALU0: ci = '{1'b1, POOL_FALU, 5'd4,  5'd1};
      CLS_FALU1: ci = '{1'b1, POOL_FALU, 5'd8,  5'd8};
      CLS_FALU2: ci = '{1'b1, POOL_FALU, 5'd2,  5'd1};
      CLS_FMUL0: ci = '{1'b1, POOL_FMUL, 5'd1,  5'd1};
      CLS_FMUL1: ci = '{1'b1, POOL_FMUL, 5'd2,  5'd1};
      CLS_FMUL2: ci = '{1'b1, POOL_FMUL, 5'd4,  5'd1};
      CLS_MEM0:  ci = '{1'b1, POOL_MEM,  5'd8,  5'd8};
      CLS_MEM1:  ci = '{1'b1, POOL_MEM,  5'd16, 5'd16};
      default:   ci = '{1'b0, POOL_IALU, 5'd0,  5'd0};
    endcase
    return ci;
  endfunction

endpackage

>>> hw/rtl/fupa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_req_if
// Request channel: mode, operation class and current time.
// ----------------------------------------------------------------------------
interface fupa_req_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic [fupa_pkg::CLASS_W-1:0]       op_class;
  logic [fupa_pkg::TIME_W-1:0]        now;

  modport source (output valid, output func, output op_class, output now, input ready);
  modport sink   (input valid, input func, input op_class, input now, output ready);
endinterface

>>> hw/rtl/fupa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_rsp_if
// Result channel: grant, unit number, latency and free count.
// ----------------------------------------------------------------------------
interface fupa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               granted;
  logic [fupa_pkg::UNIT_IDX_W-1:0]    unit_index;
  logic [fupa_pkg::LAT_W-1:0]         exec_latency;
  logic [fupa_pkg::FREE_W-1:0]        free_units;

  modport source (output valid, output granted, output unit_index, output exec_latency,
                  output free_units, input ready);
  modport sink   (input valid, input granted, input unit_index, input exec_latency,
                  input free_units, output ready);
endinterface

>>> hw/rtl/functional_unit_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// functional_unit_pool_allocator
// Five pools of execution units, each a list sorted by ready time, held in
// a row of slot cells; counts ready units and claims the head unit.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     word
//  req_i    in   valid/ready   func, op_class, now
//  rsp_o    out  valid/ready   granted, unit_index, exec_latency, free_units
//  cfg      in   cfg_we_i      cfg_idx_i (pool), cfg_data_i (unit count)
//
//  Steps, one word at a time: idle takes the word, looks up the class
//  table and forms the saturated ready time now + issue latency; exec runs the
//  cell row compare, counts ready slots and shifts the claimed unit into place.
//  Reset: asynchronous; every pool holds slot i = unit i, ready time 0, and
//  four units. A count write rebuilds that pool the same way.
//  Stalls: the result sits in an output register; the next word is taken
//  while it waits, and its update holds until the register frees up.
//
module functional_unit_pool_allocator #(
  parameter int MaxUnits = fupa_pkg::MAX_UNITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fupa_req_if.sink                          req_i,
  fupa_rsp_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [fupa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fupa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CntW  = $clog2(MaxUnits + 1);
  localparam int UnitW = (MaxUnits > 1) ? $clog2(MaxUnits) : 1;
  localparam logic [CntW-1:0] CntReset =
      CntW'((MaxUnits < fupa_pkg::UNITS_RESET) ? MaxUnits : fupa_pkg::UNITS_RESET);

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  fupa_pkg::state_e state_q, state_d;
  logic             req_fire;
  logic             exec_go;
  logic             claim;

  // captured request
  logic                          func_q;
  fupa_pkg::class_info_t         info_q;
  logic [fupa_pkg::TIME_W-1:0]   now_q;
  logic [fupa_pkg::TIME_W-1:0]   rt_new_q;
  logic [fupa_pkg::TIME_W-1:0]   rt_new_d;
  logic [fupa_pkg::TIME_W:0]     rt_sum;
  fupa_pkg::class_info_t         info_d;

  // unit counts per pool
  logic [CntW-1:0] count_q [fupa_pkg::NUM_POOLS];
  logic [CntW-1:0] cfg_count;
  logic [CntW-1:0] n_units;

  // result register
  logic                              rsp_valid_q;
  logic                              granted_q;
  logic [fupa_pkg::UNIT_IDX_W-1:0]   unit_idx_q;
  logic [fupa_pkg::LAT_W-1:0]        lat_q;
  logic [fupa_pkg::FREE_W-1:0]       free_q;
  logic [CntW-1:0]                   free_cnt;

  // cell row wiring; the extra entry is the empty right boundary
  fupa_pkg::cell_ctrl_t          ctrl;
  logic [fupa_pkg::TIME_W-1:0]   time_w   [MaxUnits+1];
  logic [UnitW-1:0]              unit_w   [MaxUnits+1];
  logic [MaxUnits:0]             le_new_w;
  logic [MaxUnits-1:0]           rdy_w;
  logic [MaxUnits-1:0]           take_w;
  logic [MaxUnits-1:0]           ins_w;

  assign req_fire = req_i.valid && req_i.ready;
  assign exec_go  = (state_q == fupa_pkg::ST_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fupa_pkg::ST_IDLE: begin
        if (req_fire) state_d = fupa_pkg::ST_EXEC;
      end
      fupa_pkg::ST_EXEC: begin
        if (exec_go) state_d = fupa_pkg::ST_IDLE;
      end
      default: state_d = fupa_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready = 1'b0;
    case (state_q)
      fupa_pkg::ST_IDLE: req_i.ready = 1'b1;
      fupa_pkg::ST_EXEC: req_i.ready = 1'b0;
      default:           req_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fupa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // class lookup and saturated ready time of a claim
  assign info_d   = fupa_pkg::class_info(req_i.op_class);
  assign rt_sum   = {1'b0, req_i.now} + (fupa_pkg::TIME_W + 1)'(info_d.issue_lat);
  assign rt_new_d = rt_sum[fupa_pkg::TIME_W] ? '1 : rt_sum[fupa_pkg::TIME_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q   <= req_i.func;
      info_q   <= info_d;
      now_q    <= req_i.now;
      rt_new_q <= rt_new_d;
    end
  end

  // unit count write: 0 reads as 1, above the slot count as the slot count
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_count = CntW'(1);
    end else if (int'(cfg_data_i) > MaxUnits) begin
      cfg_count = CntW'(MaxUnits);
    end else begin
      cfg_count = CntW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fupa_pkg::NUM_POOLS; p++) count_q[p] <= CntReset;
    end else if (cfg_we_i && int'(cfg_idx_i) < fupa_pkg::NUM_POOLS) begin
      count_q[cfg_idx_i] <= cfg_count;
    end
  end

  assign n_units = count_q[info_q.pool];

  // --------------------------------------------------------------------------
  // cell row
  // --------------------------------------------------------------------------
  // only the head can be claimed, and only when it is ready
  assign claim = exec_go && info_q.has_pool && (func_q == fupa_pkg::FUNC_CLAIM) && rdy_w[0];

  always_comb begin
    ctrl.claim    = claim;
    ctrl.cfg_we   = cfg_we_i && int'(cfg_idx_i) < fupa_pkg::NUM_POOLS;
    ctrl.cfg_pool = cfg_idx_i;
    ctrl.pool     = info_q.pool;
    ctrl.now      = now_q;
    ctrl.rt_new   = rt_new_q;
  end

  assign time_w[MaxUnits]   = '0;
  assign unit_w[MaxUnits]   = '0;
  assign le_new_w[MaxUnits] = 1'b0;

  for (genvar i = 0; i < MaxUnits; i++) begin : g_cell
    logic rdy_prev;
    logic take_prev;

    if (i == 0) begin : g_head
      // the head slot is always vacated by a claim
      assign rdy_prev  = 1'b1;
      assign take_prev = 1'b1;
    end else begin : g_body
      assign rdy_prev  = rdy_w[i-1];
      assign take_prev = take_w[i-1];
    end

    fupa_cell #(
      .MaxUnits (MaxUnits),
      .Idx      (i),
      .CntW     (CntW),
      .UnitW    (UnitW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .n_units_i   (n_units),
      .new_unit_i  (unit_w[0]),
      .rdy_prev_i  (rdy_prev),
      .take_prev_i (take_prev),
      .nb_time_i   (time_w[i+1]),
      .nb_unit_i   (unit_w[i+1]),
      .nb_le_new_i (le_new_w[i+1]),
      .time_o      (time_w[i]),
      .unit_o      (unit_w[i]),
      .le_new_o    (le_new_w[i]),
      .rdy_o       (rdy_w[i]),
      .take_o      (take_w[i]),
      .ins_o       (ins_w[i])
    );
  end

  // ready slots form a prefix of the list
  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < MaxUnits; i++) begin
      free_cnt = free_cnt + CntW'(rdy_w[i]);
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (exec_go) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      granted_q  <= claim;
      unit_idx_q <= claim ? fupa_pkg::UNIT_IDX_W'(unit_w[0]) : '0;
      lat_q      <= claim ? info_q.exec_lat : '0;
      free_q     <= info_q.has_pool ? fupa_pkg::FREE_W'(free_cnt) : '0;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.granted      = granted_q;
  assign rsp_o.unit_index   = unit_idx_q;
  assign rsp_o.exec_latency = lat_q;
  assign rsp_o.free_units   = free_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_one_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claim |-> $onehot(ins_w))
    else $error("claim did not place the unit in exactly one slot");

  a_no_insert_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !claim |-> ins_w == '0)
    else $error("slot took a unit without a claim");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |-> free_cnt <= n_units)
    else $error("free count above pool size");

  a_deny_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.granted |-> rsp_o.unit_index == '0 && rsp_o.exec_latency == '0)
    else $error("denied result carries unit or latency");

  a_exec_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fupa_pkg::ST_EXEC && !exec_go |=> state_q == fupa_pkg::ST_EXEC && $stable(now_q))
    else $error("pending request lost while result register full");

endmodule

>>> hw/rtl/fupa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_cell
// One slot position of the sorted unit lists, for all pools at once.
// ----------------------------------------------------------------------------
module fupa_cell #(
  parameter int MaxUnits = fupa_pkg::MAX_UNITS,
  parameter int Idx      = 0,
  parameter int CntW     = $clog2(MaxUnits + 1),
  parameter int UnitW    = (MaxUnits > 1) ? $clog2(MaxUnits) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fupa_pkg::cell_ctrl_t          ctrl_i,
  input  logic [CntW-1:0]               n_units_i,
  input  logic [UnitW-1:0]              new_unit_i,
  input  logic                          rdy_prev_i,
  input  logic                          take_prev_i,
  input  logic [fupa_pkg::TIME_W-1:0]   nb_time_i,
  input  logic [UnitW-1:0]              nb_unit_i,
  input  logic                          nb_le_new_i,
  output logic [fupa_pkg::TIME_W-1:0]   time_o,
  output logic [UnitW-1:0]              unit_o,
  output logic                          le_new_o,
  output logic                          rdy_o,
  output logic                          take_o,
  output logic                          ins_o
);

  localparam logic [CntW-1:0] IdxC    = CntW'(Idx);
  localparam logic [CntW-1:0] IdxNext = CntW'(Idx + 1);

  logic [fupa_pkg::TIME_W-1:0] time_q [fupa_pkg::NUM_POOLS];
  logic [fupa_pkg::TIME_W-1:0] time_d [fupa_pkg::NUM_POOLS];
  logic [UnitW-1:0]            unit_q [fupa_pkg::NUM_POOLS];
  logic [UnitW-1:0]            unit_d [fupa_pkg::NUM_POOLS];
  logic                        active;
  logic                        take_next;

  assign active    = IdxC < n_units_i;
  assign take_next = (IdxNext < n_units_i) && nb_le_new_i;

  assign time_o   = time_q[ctrl_i.pool];
  assign unit_o   = unit_q[ctrl_i.pool];
  assign le_new_o = time_o <= ctrl_i.rt_new;
  assign rdy_o    = rdy_prev_i && active && (time_o <= ctrl_i.now);
  assign take_o   = take_next;
  assign ins_o    = ctrl_i.claim && active && take_prev_i && !take_next;

  // on a claim: pull from the right neighbor while its time is at or before
  // the new time, the first cell that stops pulling takes the claimed unit
  always_comb begin
    for (int p = 0; p < fupa_pkg::NUM_POOLS; p++) begin
      time_d[p] = time_q[p];
      unit_d[p] = unit_q[p];
      if (ctrl_i.cfg_we && ctrl_i.cfg_pool == fupa_pkg::POOL_W'(p)) begin
        time_d[p] = '0;
        unit_d[p] = UnitW'(Idx);
      end else if (ctrl_i.claim && active && ctrl_i.pool == fupa_pkg::POOL_W'(p)) begin
        if (take_next) begin
          time_d[p] = nb_time_i;
          unit_d[p] = nb_unit_i;
        end else if (take_prev_i) begin
          time_d[p] = ctrl_i.rt_new;
          unit_d[p] = new_unit_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fupa_pkg::NUM_POOLS; p++) begin
        time_q[p] <= '0;
        unit_q[p] <= UnitW'(Idx);
      end
    end else begin
      for (int p = 0; p < fupa_pkg::NUM_POOLS; p++) begin
        time_q[p] <= time_d[p];
        unit_q[p] <= unit_d[p];
      end
    end
  end

endmodule
